### hdl/kiddie_ride_bus_glue_and_display_link_defines.svh
// Assertion helpers used by the checker file.
`ifndef KIDDIE_RIDE_BUS_GLUE_AND_DISPLAY_LINK_DEFINES_SVH
`define KIDDIE_RIDE_BUS_GLUE_AND_DISPLAY_LINK_DEFINES_SVH

// Property checked on every rising clock edge, off while reset is held.
`define KRBG_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must hold in the cycle after a trigger.
`define KRBG_ASSERT_NEXT(lbl, clk, rst_n, trig, cond, msg) \
  `KRBG_ASSERT(lbl, clk, rst_n, (trig) |=> (cond), msg)

`endif

### hdl/krbg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package krbg_pkg;

  localparam logic [1:0] KIND_PORT_A_WR = 2'd0;
  localparam logic [1:0] KIND_PORT_B_WR = 2'd1;
  localparam logic [1:0] KIND_PORT_B_RD = 2'd2;

  localparam logic [7:0] DIP_BUS_HI  = 8'hc0;
  localparam logic [7:0] FULL_DRIVE  = 8'hff;
  localparam logic [3:0] PORT_A_IDLE = 4'hf;
  localparam logic [5:0] DIP_RESET   = 6'h3f;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] port_data;
    logic [7:0] drive_mask;
    logic [7:0] input_pins;
    logic [7:0] oki_status;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       oki_write;
    logic [7:0] oki_command;
    logic       coin_counter;
    logic       aux_out;
    logic [1:0] lamps;
    logic       motor_on;
    logic [6:0] credits_tens;
    logic [6:0] credits_units;
    logic [6:0] time_tens;
    logic [6:0] time_units;
  } out_item_t;

  typedef struct packed {
    logic       strobe;
    logic [7:0] value;
  } latch_ev_t;

  typedef struct packed {
    logic [6:0] credits_tens;
    logic [6:0] credits_units;
    logic [6:0] time_tens;
    logic [6:0] time_units;
  } digits_t;

endpackage

`default_nettype wire

### hdl/krbg_bus.sv
`timescale 1ns / 1ps
`default_nettype none

module krbg_bus (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  step_i,
  input  krbg_pkg::in_item_t   item_i,
  input  wire  [5:0]           dip_i,
  output logic [7:0]           read_data_o,
  output logic                 oki_write_o,
  output logic [7:0]           oki_command_o,
  output krbg_pkg::latch_ev_t  latch_ev_o
);

  logic [3:0] port_a_q, port_a_d;
  logic [7:0] port_b_val_q, port_b_val_d;
  logic [7:0] port_b_drv_q, port_b_drv_d;
  logic [3:0] new_level;

  function automatic logic [7:0] bus_sel(input logic [3:0] lv, input logic [5:0] dip,
                                         input logic [7:0] pins, input logic [7:0] status);
    logic [7:0] res;
    if (!lv[1] && !lv[3]) begin
      res = krbg_pkg::DIP_BUS_HI | {2'b00, dip};
    end else if (!lv[0] && !lv[3]) begin
      res = status;
    end else begin
      res = pins;
    end
    return res;
  endfunction

  always_comb begin
    new_level     = (item_i.port_data[3:0] & item_i.drive_mask[3:0]) | ~item_i.drive_mask[3:0];
    port_a_d      = port_a_q;
    port_b_val_d  = port_b_val_q;
    port_b_drv_d  = port_b_drv_q;
    read_data_o   = '0;
    oki_write_o   = 1'b0;
    oki_command_o = '0;
    latch_ev_o    = '0;
    case (item_i.kind)
      krbg_pkg::KIND_PORT_A_WR: begin
        port_a_d = new_level;
        if (!port_a_q[1] && new_level[1] && !port_a_q[0] &&
            port_b_drv_q == krbg_pkg::FULL_DRIVE) begin
          oki_write_o   = 1'b1;
          oki_command_o = port_b_val_q;
        end
        latch_ev_o.strobe = !port_a_q[2] && new_level[2];
        latch_ev_o.value  = (port_b_val_q & port_b_drv_q) |
                            (bus_sel(new_level, dip_i, item_i.input_pins, item_i.oki_status)
                             & ~port_b_drv_q);
      end
      krbg_pkg::KIND_PORT_B_WR: begin
        port_b_val_d = item_i.port_data;
        port_b_drv_d = item_i.drive_mask;
      end
      krbg_pkg::KIND_PORT_B_RD: begin
        read_data_o = bus_sel(port_a_q, dip_i, item_i.input_pins, item_i.oki_status);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      port_a_q     <= krbg_pkg::PORT_A_IDLE;
      port_b_val_q <= krbg_pkg::FULL_DRIVE;
      port_b_drv_q <= '0;
    end else if (step_i) begin
      port_a_q     <= port_a_d;
      port_b_val_q <= port_b_val_d;
      port_b_drv_q <= port_b_drv_d;
    end
  end

endmodule

`default_nettype wire

### hdl/krbg_link.sv
`timescale 1ns / 1ps
`default_nettype none

module krbg_link (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  step_i,
  input  krbg_pkg::latch_ev_t  latch_ev_i,
  output logic [7:0]           latch_o,
  output krbg_pkg::digits_t    digits_o
);

  logic [7:0]        latch_q, latch_d;
  logic [15:0]       shift_q, shift_d;
  krbg_pkg::digits_t digits_q, digits_d;
  logic [6:0]        hi, lo, units, tens;

  always_comb begin
    latch_d  = latch_ev_i.strobe ? latch_ev_i.value : latch_q;
    shift_d  = shift_q;
    digits_d = digits_q;
    // Q1 falling edge shifts in Q0
    if (latch_q[1] && !latch_d[1]) begin
      shift_d = {shift_q[14:0], latch_d[0]};
    end
    hi    = shift_d[14:8];
    lo    = shift_d[6:0];
    units = {hi[1], hi[5], hi[4], hi[3], hi[2], hi[0], hi[6]};
    tens  = {lo[5], lo[6], lo[2], lo[3], lo[4], lo[1], lo[0]};
    // Q2 rising edge latches the frame
    if (!latch_q[2] && latch_d[2]) begin
      if (shift_d[15]) begin
        digits_d.credits_tens  = tens;
        digits_d.credits_units = units;
      end
      if (shift_d[7]) begin
        digits_d.time_tens  = tens;
        digits_d.time_units = units;
      end
    end
    latch_o  = latch_d;
    digits_o = digits_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latch_q  <= '0;
      shift_q  <= '0;
      digits_q <= '0;
    end else if (step_i) begin
      latch_q  <= latch_d;
      shift_q  <= shift_d;
      digits_q <= digits_d;
    end
  end

endmodule

`default_nettype wire

### hdl/kiddie_ride_bus_glue_and_display_link.sv
// An accepted beat waits in the input register, passes the decode/edge logic and is
// written to the result register when the output is free, then offered on the output.
// Throughput: one beat per cycle while the output is not stalled; input register, one pass
// of decode/edge logic, result register.
// Reset (rst_ni low, asynchronous): port A lines high, port B value 0xff undriven,
// latch, link shift and digits cleared, DIP register 0x3f, both stages empty.
`timescale 1ns / 1ps
`default_nettype none

module kiddie_ride_bus_glue_and_display_link (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  krbg_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output krbg_pkg::out_item_t  out_data_o,
  input  wire                  cfg_we_i,
  input  wire  [5:0]           cfg_data_i
);

  logic                 s1_valid_q;
  krbg_pkg::in_item_t   s1_item_q;
  logic                 out_valid_q;
  krbg_pkg::out_item_t  out_q, out_d;
  logic [5:0]           dip_q;
  logic                 adv, step;
  logic [7:0]           read_data, oki_command, latch;
  logic                 oki_write;
  krbg_pkg::latch_ev_t  latch_ev;
  krbg_pkg::digits_t    digits;

  assign adv        = !out_valid_q || out_ready_i;
  assign step       = s1_valid_q && adv;
  assign in_ready_o = !s1_valid_q || adv;

  krbg_bus u_bus (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .item_i        (s1_item_q),
    .dip_i         (dip_q),
    .read_data_o   (read_data),
    .oki_write_o   (oki_write),
    .oki_command_o (oki_command),
    .latch_ev_o    (latch_ev)
  );

  krbg_link u_link (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .latch_ev_i (latch_ev),
    .latch_o    (latch),
    .digits_o   (digits)
  );

  always_comb begin
    out_d.read_data     = read_data;
    out_d.oki_write     = oki_write;
    out_d.oki_command   = oki_command;
    out_d.coin_counter  = latch[3];
    out_d.aux_out       = latch[4];
    out_d.lamps         = latch[6:5];
    out_d.motor_on      = latch[7];
    out_d.credits_tens  = digits.credits_tens;
    out_d.credits_units = digits.credits_units;
    out_d.time_tens     = digits.time_tens;
    out_d.time_units    = digits.time_units;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      dip_q       <= krbg_pkg::DIP_RESET;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (adv) begin
        out_valid_q <= s1_valid_q;
      end
      if (cfg_we_i) begin
        dip_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_item_q <= in_data_i;
    end
    if (step) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

### hdl/krbg_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "kiddie_ride_bus_glue_and_display_link_defines.svh"

module krbg_checker (
  input wire                  clk_i,
  input wire                  rst_ni,
  input wire                  in_ready_o,
  input wire                  out_valid_o,
  input wire                  out_ready_i,
  input krbg_pkg::out_item_t  out_data_o
);

  `KRBG_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o, "output beat dropped while stalled")
  `KRBG_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(out_data_o), "output beat changed while stalled")
  `KRBG_ASSERT(a_stall_cause, clk_i, rst_ni, !in_ready_o |-> (out_valid_o && !out_ready_i), "input stalled without output backpressure")
  `KRBG_ASSERT(a_cmd_gated, clk_i, rst_ni, (out_valid_o && !out_data_o.oki_write) |-> (out_data_o.oki_command == 8'h00), "sound command byte without write")
  `KRBG_ASSERT(a_read_no_cmd, clk_i, rst_ni, (out_valid_o && out_data_o.read_data != 8'h00) |-> !out_data_o.oki_write, "read beat issued a sound command")

endmodule

bind kiddie_ride_bus_glue_and_display_link krbg_checker u_krbg_checker (.*);

`default_nettype wire

### tb/kiddie_ride_bus_glue_and_display_link_tb.sv
`timescale 1ns / 1ps

module kiddie_ride_bus_glue_and_display_link_tb;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 200_000;
  localparam int SETTLE_CYCLES = 4;

  typedef struct {
    krbg_pkg::in_item_t beat;
    bit                 drain;
  } port_event_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  krbg_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  krbg_pkg::out_item_t out_data;
  logic                cfg_we = 1'b0;
  logic [5:0]          cfg_data = '0;

  kiddie_ride_bus_glue_and_display_link dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data)
  );

  // board state as the predictor sees it
  logic [5:0] dip_lvl = krbg_pkg::DIP_RESET;
  logic [3:0] pa_lvl = krbg_pkg::PORT_A_IDLE;
  logic [7:0] pb_val = '1;
  logic [7:0] pb_drv = '0;
  logic [7:0] latch_q = '0;
  logic [15:0] link_sr = '0;
  logic [6:0] digits [4] = '{default: '0};

  port_event_t         port_events [$];
  krbg_pkg::out_item_t due_responses [$];
  port_event_t         head_event;
  krbg_pkg::out_item_t want_resp;

  int accept_cnt = 0;
  int result_cnt = 0;
  int err_cnt = 0;
  int cycle_cnt = 0;
  int cmd_cnt = 0;
  int frame_cnt = 0;
  int gen_cnt = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_next = 1'b0;

  initial forever #5 clk = ~clk;

  function automatic logic [7:0] decode_bus(logic [7:0] pins, logic [7:0] status);
    if (!pa_lvl[1] && !pa_lvl[3]) return krbg_pkg::DIP_BUS_HI | {2'b00, dip_lvl};
    if (!pa_lvl[0] && !pa_lvl[3]) return status;
    return pins;
  endfunction

  function automatic void store_frame();
    logic [6:0] hi;
    logic [6:0] lo;
    logic [6:0] units;
    logic [6:0] tens;
    hi = link_sr[14:8];
    lo = link_sr[6:0];
    units = {hi[1], hi[5], hi[4], hi[3], hi[2], hi[0], hi[6]};
    tens  = {lo[5], lo[6], lo[2], lo[3], lo[4], lo[1], lo[0]};
    if (link_sr[15]) begin
      digits[0] = tens;
      digits[1] = units;
    end
    if (link_sr[7]) begin
      digits[2] = tens;
      digits[3] = units;
    end
    if (link_sr[15] || link_sr[7]) frame_cnt++;
  endfunction

  function automatic void clock_latch(logic [7:0] v);
    logic [7:0] prev;
    prev = latch_q;
    latch_q = v;
    // shift before the frame store when both edges land together
    if (prev[1] && !v[1]) link_sr = {link_sr[14:0], v[0]};
    if (!prev[2] && v[2]) store_frame();
  endfunction

  function automatic krbg_pkg::out_item_t predict_event(krbg_pkg::in_item_t ev);
    krbg_pkg::out_item_t r;
    logic [3:0] prev;
    logic [3:0] nxt;
    r = '0;
    case (ev.kind)
      krbg_pkg::KIND_PORT_A_WR: begin
        prev = pa_lvl;
        nxt = (ev.port_data[3:0] & ev.drive_mask[3:0]) | ~ev.drive_mask[3:0];
        pa_lvl = nxt;
        if (!prev[1] && nxt[1] && !prev[0] && pb_drv == krbg_pkg::FULL_DRIVE) begin
          r.oki_write = 1'b1;
          r.oki_command = pb_val;
          cmd_cnt++;
        end
        if (!prev[2] && nxt[2])
          clock_latch((pb_val & pb_drv) | (decode_bus(ev.input_pins, ev.oki_status) & ~pb_drv));
      end
      krbg_pkg::KIND_PORT_B_WR: begin
        pb_val = ev.port_data;
        pb_drv = ev.drive_mask;
      end
      krbg_pkg::KIND_PORT_B_RD: r.read_data = decode_bus(ev.input_pins, ev.oki_status);
      default: ;
    endcase
    r.coin_counter = latch_q[3];
    r.aux_out = latch_q[4];
    r.lamps = latch_q[6:5];
    r.motor_on = latch_q[7];
    r.credits_tens = digits[0];
    r.credits_units = digits[1];
    r.time_tens = digits[2];
    r.time_units = digits[3];
    return r;
  endfunction

  // driver
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
      accept_cnt <= 0;
    end else begin
      if (in_valid && in_ready) begin
        due_responses.push_back(predict_event(in_data));
        accept_cnt <= accept_cnt + 1;
      end
      if (!in_valid || in_ready) begin
        if (port_events.size() != 0 &&
            !(port_events[0].drain && (in_valid || accept_cnt != result_cnt)) &&
            $urandom_range(99) >= send_idle_pct) begin
          head_event = port_events.pop_front();
          in_valid <= 1'b1;
          in_data <= head_event.beat;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic cmp(string fld, int unsigned want, int unsigned got);
    if (want != got) begin
      if (err_cnt < 10)
        $display("mismatch on beat %0d: %s expected 0x%0h actual 0x%0h",
                 result_cnt, fld, want, got);
      err_cnt++;
    end
  endtask

  // monitor
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      result_cnt <= 0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
      if (out_valid && out_ready) begin
        result_cnt <= result_cnt + 1;
        if (result_cnt >= accept_cnt) begin
          if (err_cnt < 10) $display("unexpected beat %0d: 0x%0h", result_cnt, out_data);
          err_cnt++;
        end else begin
          want_resp = due_responses.pop_front();
          cmp("read_data", want_resp.read_data, out_data.read_data);
          cmp("oki_write", want_resp.oki_write, out_data.oki_write);
          cmp("oki_command", want_resp.oki_command, out_data.oki_command);
          cmp("coin_counter", want_resp.coin_counter, out_data.coin_counter);
          cmp("aux_out", want_resp.aux_out, out_data.aux_out);
          cmp("lamps", want_resp.lamps, out_data.lamps);
          cmp("motor_on", want_resp.motor_on, out_data.motor_on);
          cmp("credits_tens", want_resp.credits_tens, out_data.credits_tens);
          cmp("credits_units", want_resp.credits_units, out_data.credits_units);
          cmp("time_tens", want_resp.time_tens, out_data.time_tens);
          cmp("time_units", want_resp.time_units, out_data.time_units);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [7:0] rnd8();
    return 8'($urandom_range(255));
  endfunction

  task automatic queue_beat(logic [1:0] kind, logic [7:0] data, logic [7:0] mask,
                            logic [7:0] pins, logic [7:0] status);
    port_event_t p;
    p.beat.kind = kind;
    p.beat.port_data = data;
    p.beat.drive_mask = mask;
    p.beat.input_pins = pins;
    p.beat.oki_status = status;
    p.drain = hold_next;
    hold_next = 1'b0;
    port_events.push_back(p);
    gen_cnt++;
  endtask

  // port A write with the low nibble fully driven, junk in the upper bits
  task automatic port_a(logic [3:0] lvl, logic [7:0] pins, logic [7:0] status);
    logic [7:0] d;
    logic [7:0] m;
    d = rnd8();
    m = rnd8();
    queue_beat(krbg_pkg::KIND_PORT_A_WR, {d[7:4], lvl}, {m[7:4], 4'hf}, pins, status);
  endtask

  // latch load from the raw inputs; port B must be undriven
  task automatic bus_load(logic [7:0] v);
    port_a(4'b1000, rnd8(), rnd8());
    port_a(4'b1100, v, rnd8());
  endtask

  task automatic send_frame();
    logic [15:0] word;
    logic [7:0] deco;
    bit joint;
    word = 16'($urandom_range(65535));
    if ($urandom_range(3) != 0) word[15] = 1'b1;
    if ($urandom_range(3) != 0) word[7] = 1'b1;
    joint = $urandom_range(1);
    queue_beat(krbg_pkg::KIND_PORT_B_WR, rnd8(), 8'h00, rnd8(), rnd8());
    for (int i = 15; i >= 0; i--) begin
      deco = rnd8() & 8'hf8;
      bus_load(deco | 8'h02);
      if (i == 0 && joint) bus_load(deco | 8'h04 | {7'b0, word[i]});
      else bus_load(deco | {7'b0, word[i]});
    end
    if (!joint) bus_load(8'h04 | (rnd8() & 8'hf8));
  endtask

  task automatic random_traffic(int budget);
    int start;
    int n;
    logic [3:0] lvl;
    logic [7:0] mask;
    bit hold_mid;
    start = gen_cnt;
    hold_mid = 1'b1;
    while (gen_cnt - start < budget) begin
      if (hold_mid && gen_cnt - start >= budget / 2) begin
        hold_next = 1'b1;
        hold_mid = 1'b0;
      end
      case ($urandom_range(9))
        0, 1: begin
          n = $urandom_range(1, 3);
          repeat (n) queue_beat(2'($urandom_range(3)), rnd8(), rnd8(), rnd8(), rnd8());
        end
        2, 3: begin
          port_a(4'($urandom_range(15)), rnd8(), rnd8());
          n = $urandom_range(1, 3);
          repeat (n) queue_beat(krbg_pkg::KIND_PORT_B_RD, rnd8(), rnd8(), rnd8(), rnd8());
        end
        4, 5: begin
          mask = ($urandom_range(3) == 0) ? rnd8() : krbg_pkg::FULL_DRIVE;
          queue_beat(krbg_pkg::KIND_PORT_B_WR, rnd8(), mask, rnd8(), rnd8());
          port_a(4'($urandom_range(15)) & 4'hc, rnd8(), rnd8());
          port_a((4'($urandom_range(15)) & 4'hd) | 4'h2, rnd8(), rnd8());
        end
        6, 7: begin
          case ($urandom_range(2))
            0: mask = 8'h00;
            1: mask = krbg_pkg::FULL_DRIVE;
            default: mask = rnd8();
          endcase
          queue_beat(krbg_pkg::KIND_PORT_B_WR, rnd8(), mask, rnd8(), rnd8());
          lvl = 4'($urandom_range(15));
          port_a(lvl & 4'hb, rnd8(), rnd8());
          port_a(lvl | 4'h4, rnd8(), rnd8());
        end
        default: send_frame();
      endcase
    end
  endtask

  task automatic wait_quiet();
    do @(negedge clk);
    while (port_events.size() != 0 || in_valid || accept_cnt != result_cnt);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_dip(logic [5:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    dip_lvl = v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    int send_pct [4];
    int recv_pct [4];
    logic [5:0] dip_pick [4];
    send_pct = '{0, 52, 0, 21};
    recv_pct = '{0, 0, 52, 21};
    dip_pick = '{6'h15, 6'h3f, 6'($urandom_range(63)), 6'h00};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset DIP levels: raw inputs, then the switch byte
    queue_beat(krbg_pkg::KIND_PORT_B_RD, 8'h00, 8'hff, 8'ha5, 8'h5a);
    queue_beat(krbg_pkg::KIND_PORT_A_WR, 8'hf0, 8'hfa, 8'h00, 8'hff);
    queue_beat(krbg_pkg::KIND_PORT_B_RD, 8'hff, 8'h00, 8'h00, 8'h00);
    wait_quiet();
    write_dip(6'h00);

    queue_beat(krbg_pkg::KIND_PORT_A_WR, 8'h00, 8'h0a, 8'hff, 8'h00);
    queue_beat(krbg_pkg::KIND_PORT_B_RD, 8'h00, 8'h00, 8'hff, 8'hff);
    // status select, then a sound command with port B fully driven
    queue_beat(krbg_pkg::KIND_PORT_A_WR, 8'h02, 8'hff, 8'h00, 8'h00);
    queue_beat(krbg_pkg::KIND_PORT_B_RD, 8'h00, 8'h00, 8'h7e, 8'h81);
    queue_beat(krbg_pkg::KIND_PORT_B_WR, 8'h3c, 8'hff, 8'h00, 8'h00);
    queue_beat(krbg_pkg::KIND_PORT_A_WR, 8'h00, 8'hff, 8'h00, 8'h00);
    queue_beat(krbg_pkg::KIND_PORT_A_WR, 8'h02, 8'hff, 8'h00, 8'h00);
    // bus not fully driven: no command
    queue_beat(krbg_pkg::KIND_PORT_B_WR, 8'h99, 8'h7f, 8'h00, 8'h00);
    queue_beat(krbg_pkg::KIND_PORT_A_WR, 8'h00, 8'hff, 8'h00, 8'h00);
    queue_beat(krbg_pkg::KIND_PORT_A_WR, 8'h02, 8'hff, 8'h00, 8'h00);
    // latch clock mixing port B and the status byte
    queue_beat(krbg_pkg::KIND_PORT_A_WR, 8'h06, 8'hff, 8'h00, 8'h80);
    queue_beat(krbg_pkg::KIND_PORT_B_WR, 8'hff, 8'hff, 8'h00, 8'h00);
    queue_beat(krbg_pkg::KIND_PORT_A_WR, 8'h0a, 8'hff, 8'h00, 8'h00);
    queue_beat(krbg_pkg::KIND_PORT_A_WR, 8'h0e, 8'hff, 8'h00, 8'h00);
    // latch from raw inputs: Q1 falls, link shifts
    queue_beat(krbg_pkg::KIND_PORT_B_WR, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_beat(krbg_pkg::KIND_PORT_A_WR, 8'h0a, 8'hff, 8'hff, 8'hff);
    queue_beat(krbg_pkg::KIND_PORT_A_WR, 8'h0e, 8'hff, 8'h00, 8'hff);
    queue_beat(KIND_UNUSED, 8'hff, 8'hff, 8'hff, 8'hff);
    queue_beat(krbg_pkg::KIND_PORT_A_WR, 8'h0f, 8'h00, 8'hff, 8'h00);

    for (int ph = 0; ph < 4; ph++) begin
      wait_quiet();
      write_dip(dip_pick[ph]);
      send_idle_pct = send_pct[ph];
      recv_idle_pct = recv_pct[ph];
      random_traffic(185);
    end

    wait_quiet();
    $display("Drove %0d port events through four stall mixes and six DIP settings;",
             accept_cnt);
    $display("they issued %0d sound commands and %0d display frame stores.",
             cmd_cnt, frame_cnt);
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
